// ===== hw/rtl/utf8_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODER_MACROS_SVH
`define UTF8_DECODER_MACROS_SVH

// check prop at every clock edge outside of reset
`define UTF8D_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every clock edge, reset included
`define UTF8D_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, constants and transaction types shared by the decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 16;
    localparam int REM_W  = 2;

    localparam logic [CNT_W-1:0] C_MAX_CP_RESET = 16'd1024;
    localparam logic [CNT_W-1:0] C_CNT_SAT      = 16'hFFFF;

    localparam logic [BYTE_W-1:0] C_LEAD2_MIN = 8'h80;
    localparam logic [BYTE_W-1:0] C_LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] C_LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] C_BAD_MIN   = 8'hF8;

    localparam logic [REM_W-1:0] C_REM_NONE  = 2'd0;
    localparam logic [REM_W-1:0] C_REM_ONE   = 2'd1;
    localparam logic [REM_W-1:0] C_REM_TWO   = 2'd2;
    localparam logic [REM_W-1:0] C_REM_THREE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_byte_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_string;
        logic            over_limit;
    } t_result;

endpackage

// ===== hw/rtl/utf8d_in_stage.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder input stage
// Registers one byte transaction and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module utf8d_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  utf8d_pkg::t_byte_item i_item,
    input  logic                  i_advance,
    output logic                  o_valid,
    output utf8d_pkg::t_byte_item o_item
);

    logic                  r_valid;
    utf8d_pkg::t_byte_item r_item;
    logic                  accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/utf8d_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Decodes one byte per step against the sequence state and the limit register.
// ----------------------------------------------------------------------------
`include "utf8_decoder_macros.svh"

module utf8d_core #(
    parameter logic [15:0] MAX_CP_RESET = 16'd1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [utf8d_pkg::CNT_W-1:0]  i_cfg_wr_data,
    input  logic                         i_step,
    input  utf8d_pkg::t_byte_item        i_item,
    output logic                         o_emit,
    output utf8d_pkg::t_result           o_result
);

    logic [utf8d_pkg::CNT_W-1:0] r_max_code_points;
    logic [utf8d_pkg::CP_W-1:0]  r_accumulator;
    logic [utf8d_pkg::REM_W-1:0] r_bytes_remaining;
    logic [utf8d_pkg::CNT_W-1:0] r_points_emitted;
    logic                        r_dropping;

    logic [utf8d_pkg::CP_W-1:0]  n_accumulator;
    logic [utf8d_pkg::REM_W-1:0] n_bytes_remaining;
    logic [utf8d_pkg::CNT_W-1:0] n_points_emitted;
    logic                        n_dropping;

    logic [utf8d_pkg::CP_W-1:0]  acc_upd;
    logic [utf8d_pkg::REM_W-1:0] rem_upd;
    logic [utf8d_pkg::CP_W-1:0]  padded;
    logic                        over;
    logic                        complete;
    logic                        last;

    assign last     = i_item.last_byte;
    assign over     = (r_bytes_remaining == utf8d_pkg::C_REM_NONE)
                      && (r_points_emitted >= r_max_code_points);
    assign complete = (rem_upd == utf8d_pkg::C_REM_NONE) || last;

    always_comb begin
        acc_upd = '0;
        rem_upd = utf8d_pkg::C_REM_NONE;
        if (r_bytes_remaining != utf8d_pkg::C_REM_NONE) begin
            acc_upd = {r_accumulator[utf8d_pkg::CP_W-7:0], i_item.data_byte[5:0]};
            rem_upd = r_bytes_remaining - utf8d_pkg::C_REM_ONE;
        end else begin
            case (i_item.data_byte) inside
                [8'h00:utf8d_pkg::C_LEAD2_MIN - 8'd1]: begin
                    acc_upd = {13'd0, i_item.data_byte};
                end
                [utf8d_pkg::C_LEAD2_MIN:utf8d_pkg::C_LEAD3_MIN - 8'd1]: begin
                    acc_upd = {16'd0, i_item.data_byte[4:0]};
                    rem_upd = utf8d_pkg::C_REM_ONE;
                end
                [utf8d_pkg::C_LEAD3_MIN:utf8d_pkg::C_LEAD4_MIN - 8'd1]: begin
                    acc_upd = {17'd0, i_item.data_byte[3:0]};
                    rem_upd = utf8d_pkg::C_REM_TWO;
                end
                [utf8d_pkg::C_LEAD4_MIN:utf8d_pkg::C_BAD_MIN - 8'd1]: begin
                    acc_upd = {18'd0, i_item.data_byte[2:0]};
                    rem_upd = utf8d_pkg::C_REM_THREE;
                end
                default: begin
                    acc_upd = '0;
                end
            endcase
        end
    end

    always_comb begin
        case (rem_upd)
            utf8d_pkg::C_REM_NONE:  padded = acc_upd;
            utf8d_pkg::C_REM_ONE:   padded = {acc_upd[utf8d_pkg::CP_W-7:0], 6'd0};
            utf8d_pkg::C_REM_TWO:   padded = {acc_upd[utf8d_pkg::CP_W-13:0], 12'd0};
            default:                padded = {acc_upd[utf8d_pkg::CP_W-19:0], 18'd0};
        endcase
    end

    always_comb begin
        o_emit = !r_dropping && (over || complete);
        o_result.code_point    = over ? '0 : padded;
        o_result.end_of_string = over || last;
        o_result.over_limit    = over;
    end

    always_comb begin
        n_accumulator     = r_accumulator;
        n_bytes_remaining = r_bytes_remaining;
        n_points_emitted  = r_points_emitted;
        n_dropping        = r_dropping;
        if (r_dropping || over || complete) begin
            if (last) begin
                n_accumulator     = '0;
                n_bytes_remaining = utf8d_pkg::C_REM_NONE;
                n_points_emitted  = '0;
                n_dropping        = 1'b0;
            end else if (!r_dropping && over) begin
                n_dropping = 1'b1;
            end else if (!r_dropping) begin
                n_accumulator     = '0;
                n_bytes_remaining = utf8d_pkg::C_REM_NONE;
                if (r_points_emitted != utf8d_pkg::C_CNT_SAT) begin
                    n_points_emitted = r_points_emitted + 16'd1;
                end
            end
        end else begin
            n_accumulator     = acc_upd;
            n_bytes_remaining = rem_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_code_points <= MAX_CP_RESET;
            r_accumulator     <= '0;
            r_bytes_remaining <= utf8d_pkg::C_REM_NONE;
            r_points_emitted  <= '0;
            r_dropping        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_code_points <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_accumulator     <= n_accumulator;
                r_bytes_remaining <= n_bytes_remaining;
                r_points_emitted  <= n_points_emitted;
                r_dropping        <= n_dropping;
            end
        end
    end

    `UTF8D_ASSERT_ALWAYS(a_drop_no_seq, i_clk, r_dropping |-> r_bytes_remaining == utf8d_pkg::C_REM_NONE, "dropping with open sequence")
    `UTF8D_ASSERT_RST(a_over_is_eos, i_clk, i_rst_n, (o_emit && o_result.over_limit) |-> (o_result.end_of_string && o_result.code_point == '0), "over-limit result malformed")
    `UTF8D_ASSERT_RST(a_last_clears, i_clk, i_rst_n, (i_step && last) |=> (r_points_emitted == '0 && r_bytes_remaining == utf8d_pkg::C_REM_NONE && !r_dropping), "state not cleared at end of string")
    `UTF8D_ASSERT_RST(a_drop_silent, i_clk, i_rst_n, r_dropping |-> !o_emit, "result while dropping")

endmodule

// ===== hw/rtl/utf8_decoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder top level
// Byte stream in, code points out, with a per-string code point limit.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one byte (i_data_byte) and its
// end marker (i_last_byte). Output channel: o_out_valid / i_out_stall carry
// one code point with end_of_string and over_limit flags.
// A transaction moves on an edge with valid high and stall low.
// Path: a byte that completes a result is registered in the input stage,
// decoded combinationally in the core, and the result is registered in the
// output register.
// Throughput: one byte per cycle while the output is not stalled; the
// decode step between the two registers is combinational. Bytes that leave
// a sequence open and dropped bytes yield no result.
// Limit: i_cfg_wr_en writes i_cfg_wr_data to the code point limit; write it
// only while no transaction is in flight.
// Reset: sequence state, counts and both stages clear; the limit returns to
// MAX_CP_RESET. No clearing pass.
// Stall: a stalled result holds; an empty input stage still takes one more
// byte, then o_in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module utf8_decoder #(
    parameter logic [15:0] MAX_CP_RESET = 16'd1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic        o_end_of_string,
    output logic        o_over_limit
);

    utf8d_pkg::t_byte_item in_item;
    utf8d_pkg::t_byte_item stage_item;
    utf8d_pkg::t_result    core_result;
    utf8d_pkg::t_result    r_out;
    logic                  r_out_valid;
    logic                  stage_valid;
    logic                  advance;
    logic                  step;
    logic                  core_emit;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    assign advance = !r_out_valid || !i_out_stall;
    assign step    = stage_valid && advance;

    utf8d_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    utf8d_core #(
        .MAX_CP_RESET (MAX_CP_RESET)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_item        (stage_item),
        .o_emit        (core_emit),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && core_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_code_point    = r_out.code_point;
    assign o_end_of_string = r_out.end_of_string;
    assign o_over_limit    = r_out.over_limit;

endmodule

// ===== dv/utf8_decoder_test.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder regression
// Feeds byte strings through the decoder, with random sender bursts and
// gaps and random receiver stalls. A behavioral decoder runs on every
// accepted byte, and each code point that comes out is checked in order
// against the queue of predictions. The run covers several limit settings,
// including 0, 1 and 65535.
// ----------------------------------------------------------------------------
module utf8_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8d_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 650;
    localparam int HOLD_CYCLES  = 300;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [20:0] o_code_point;
    logic        o_end_of_string;
    logic        o_over_limit;

    utf8_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_point    (o_code_point),
        .o_end_of_string (o_end_of_string),
        .o_over_limit    (o_over_limit)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    t_byte_item pending_bytes[$];
    t_result    expected_points[$];

    // decoder state mirror
    logic [CP_W-1:0]  cp_acc;
    logic [REM_W-1:0] conts_left;
    logic [CNT_W-1:0] points_done;
    logic             drop_rest;
    logic [CNT_W-1:0] cp_limit;

    logic        in_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    int cycle_count = 0;
    int mismatch_count = 0;
    int points_checked = 0;
    int over_limit_seen = 0;
    int bytes_taken = 0;
    int in_stall_cycles = 0;
    int limit_settings = 0;
    int random_bytes = 0;

    function automatic void clear_string();
        cp_acc = '0;
        conts_left = C_REM_NONE;
        points_done = '0;
        drop_rest = 1'b0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_result res);
        logic [CP_W-1:0] cp;
        res = '0;
        if (drop_rest) begin
            if (last)
                clear_string();
            return 1'b0;
        end
        if (conts_left != C_REM_NONE) begin
            cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
            conts_left = conts_left - 1'b1;
        end else begin
            if (points_done >= cp_limit) begin
                res.end_of_string = 1'b1;
                res.over_limit = 1'b1;
                if (last)
                    clear_string();
                else
                    drop_rest = 1'b1;
                return 1'b1;
            end
            if (b < C_LEAD2_MIN) begin
                cp_acc = CP_W'(b);
            end else if (b < C_LEAD3_MIN) begin
                cp_acc = CP_W'(b & 8'h1F);
                conts_left = C_REM_ONE;
            end else if (b < C_LEAD4_MIN) begin
                cp_acc = CP_W'(b & 8'h0F);
                conts_left = C_REM_TWO;
            end else if (b < C_BAD_MIN) begin
                cp_acc = CP_W'(b & 8'h07);
                conts_left = C_REM_THREE;
            end else begin
                cp_acc = '0;
            end
        end
        if (conts_left != C_REM_NONE && !last)
            return 1'b0;
        // pad missing continuations with zero bits
        cp = cp_acc << (6 * conts_left);
        res.code_point = cp;
        res.end_of_string = last;
        if (last) begin
            clear_string();
        end else begin
            cp_acc = '0;
            conts_left = C_REM_NONE;
            if (points_done != C_CNT_SAT)
                points_done = points_done + 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected cp=%06h eos=%0b over=%0b, got cp=%06h eos=%0b over=%0b",
                     $time, what, want.code_point, want.end_of_string, want.over_limit,
                     got.code_point, got.end_of_string, got.over_limit);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cp_limit = C_MAX_CP_RESET;
            clear_string();
            in_taken <= 1'b0;
        end else begin
            if (i_cfg_wr_en)
                cp_limit = i_cfg_wr_data;
            if (o_in_stall)
                in_stall_cycles++;
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                bytes_taken++;
                if (decode_byte(i_data_byte, i_last_byte, want))
                    expected_points.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got.code_point = o_code_point;
                got.end_of_string = o_end_of_string;
                got.over_limit = o_over_limit;
                if (o_over_limit)
                    over_limit_seen++;
                if (expected_points.size() == 0) begin
                    flag_mismatch("unexpected code point", '0, got);
                end else begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (got.code_point !== want.code_point
                            || got.end_of_string !== want.end_of_string
                            || got.over_limit !== want.over_limit)
                        flag_mismatch("code point mismatch", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_byte_item item;
        logic       next_valid;
        next_valid = i_in_valid && !in_taken;
        if (i_rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_bytes.size() != 0) begin
                item = pending_bytes.pop_front();
                i_data_byte <= item.data_byte;
                i_last_byte <= item.last_byte;
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= next_valid;
    end

    always @(negedge i_clk) begin
        logic next_stall;
        next_stall = 1'b0;
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE: next_stall = 1'b0;
                STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
                STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
                STALL_ALTERNATE: next_stall = !i_out_stall;
                default: next_stall = 1'b0;
            endcase
        end
        i_out_stall <= next_stall;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t timeout with %0d code points outstanding", $time,
                     expected_points.size());
            $display("utf8_decoder regression: fail");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back({b, last});
    endtask

    task automatic push_random_string(input int n_chars);
        logic [7:0] seq[$];
        int         roll;
        int         n_cont;
        int         cut;
        for (int c = 0; c < n_chars; c++) begin
            roll = $urandom_range(0, 99);
            n_cont = 0;
            if (roll < 40) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else if (roll < 60) begin
                seq.push_back(8'($urandom_range(8'h80, 8'hDF)));
                n_cont = 1;
            end else if (roll < 75) begin
                seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                n_cont = 2;
            end else if (roll < 88) begin
                seq.push_back(8'($urandom_range(8'hF0, 8'hF7)));
                n_cont = 3;
            end else if (roll < 94) begin
                seq.push_back(8'($urandom_range(8'hF8, 8'hFF)));
            end else begin
                seq.push_back(8'($urandom));
            end
            repeat (n_cont)
                seq.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                           : {2'b10, 6'($urandom)});
        end
        // cut the string short now and then
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut)
                void'(seq.pop_back());
        end
        foreach (seq[k])
            push_byte(seq[k], k == seq.size() - 1);
        random_bytes += seq.size();
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_settings++;
    endtask

    initial begin
        logic [15:0] limit;
        int          phase;
        int          max_chars;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // top of each lead class, 00 and 80, bad leads, cut strings
        push_byte(8'h00, 1'b0); push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'hBF, 1'b0);
        push_byte(8'hDF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hEF, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
        push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
        push_byte(8'hF8, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hE2, 1'b1);
        push_byte(8'hF4, 1'b0); push_byte(8'h8F, 1'b1);
        wait_drained();

        // limit of one: over-limit mid-string and on the last byte
        write_limit(16'd1);
        push_byte(8'h41, 1'b0); push_byte(8'h42, 1'b0); push_byte(8'h43, 1'b1);
        push_byte(8'h41, 1'b0); push_byte(8'hE2, 1'b1);
        push_byte(8'h80, 1'b0); push_byte(8'h81, 1'b0); push_byte(8'h82, 1'b1);
        wait_drained();

        // hold off the receiver while the sender keeps pushing
        write_limit(C_MAX_CP_RESET);
        @(posedge i_clk);
        hold_requests++;
        repeat (12) push_random_string($urandom_range(2, 8));
        wait_drained();

        phase = 0;
        while (random_bytes < RANDOM_BYTES) begin
            case (phase)
                0: limit = 16'd0;
                1: limit = 16'hFFFF;
                2: limit = 16'd1;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: limit = 16'($urandom_range(1, 6));
                        6, 7: limit = 16'($urandom_range(7, 40));
                        8: limit = 16'hFFFF;
                        default: limit = 16'($urandom_range(0, 2));
                    endcase
                end
            endcase
            write_limit(limit);
            max_chars = (limit + 3 > 14) ? 14 : limit + 3;
            repeat ($urandom_range(3, 8)) push_random_string($urandom_range(1, max_chars));
            wait_drained();
            phase++;
        end

        $display("decoded %0d bytes into %0d checked code points (%0d over-limit)",
                 bytes_taken, points_checked, over_limit_seen);
        $display("%0d limit writes, input held back on %0d cycles, %0d mismatches",
                 limit_settings, in_stall_cycles, mismatch_count);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("utf8_decoder regression: pass");
        else
            $display("utf8_decoder regression: fail");
        $finish;
    end

endmodule
